[design/gtg_pkg.sv]
// Shared types, constants and the arctangent table of the go-to-goal controller.
package gtg_pkg;

  localparam int unsigned DIFF_W = 33;
  localparam int unsigned CORD_W = 36;
  localparam int unsigned ANG_W  = 34;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = 32;

  localparam logic signed [ANG_W-1:0] PI_Q29     = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q29 = 34'sd3373259426;

  localparam logic [31:0] GOAL_X_RST       = 32'd0;
  localparam logic [31:0] GOAL_Y_RST       = 32'd0;
  localparam logic [15:0] LINEAR_GAIN_RST  = 16'd128;
  localparam logic [15:0] ANGULAR_GAIN_RST = 16'd768;
  localparam logic [31:0] STOP_DIST_RST    = 32'd3277;

  typedef enum logic [2:0] {
    CFG_GOAL_X       = 3'd0,
    CFG_GOAL_Y       = 3'd1,
    CFG_LINEAR_GAIN  = 3'd2,
    CFG_ANGULAR_GAIN = 3'd3,
    CFG_STOP_DIST    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic [30:0]        linear_speed;
    logic signed [31:0] angular_speed;
    logic               arrived;
  } cmd_t;

  function automatic logic [29:0] atan_q29(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd421657428;
      5'd1:    val = 30'd248918915;
      5'd2:    val = 30'd131521918;
      5'd3:    val = 30'd66762579;
      5'd4:    val = 30'd33510843;
      5'd5:    val = 30'd16771758;
      5'd6:    val = 30'd8387925;
      5'd7:    val = 30'd4194219;
      5'd8:    val = 30'd2097141;
      5'd9:    val = 30'd1048575;
      default: val = 30'h2000_0000 >> idx;
    endcase
    return val;
  endfunction

endpackage

[design/gtg_if.sv]
// Pose and command stream interfaces of the go-to-goal controller.
interface gtg_pose_if;
  logic           valid;
  logic           ready;
  gtg_pkg::pose_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gtg_cmd_if;
  logic          valid;
  logic          ready;
  gtg_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/gtg_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module gtg_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [gtg_pkg::RAD_W-1:0]       radicand_i,
  output logic                            busy_o,
  output logic [gtg_pkg::ROOT_W-1:0]      root_o
);

  localparam int unsigned REM_W = gtg_pkg::ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(gtg_pkg::ROOT_W);

  logic                        busy_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [gtg_pkg::RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]            rem_q;
  logic [gtg_pkg::ROOT_W-1:0]  root_q;
  logic [REM_W+1:0]            rem_sh;
  logic [REM_W+1:0]            trial;
  logic [REM_W+1:0]            diff;
  logic                        fits;

  assign rem_sh = {rem_q, rad_q[gtg_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(gtg_pkg::ROOT_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[gtg_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[gtg_pkg::ROOT_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[design/gtg_cordic.sv]
// Iterative CORDIC in vectoring mode giving the bearing of a vector in Q5.29 radians.
module gtg_cordic #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [gtg_pkg::DIFF_W-1:0]   x_i,
  input  logic signed [gtg_pkg::DIFF_W-1:0]   y_i,
  output logic                                busy_o,
  output logic signed [gtg_pkg::ANG_W-1:0]    angle_o
);

  localparam int unsigned NITER = (ITERATIONS > 32) ? 32 : ITERATIONS;
  localparam int unsigned IW    = (NITER > 1) ? $clog2(NITER) : 1;

  logic                               busy_q;
  logic [IW-1:0]                      iter_q;
  logic signed [gtg_pkg::CORD_W-1:0]  x_q;
  logic signed [gtg_pkg::CORD_W-1:0]  y_q;
  logic signed [gtg_pkg::ANG_W-1:0]   z_q;
  logic signed [gtg_pkg::CORD_W-1:0]  xs;
  logic signed [gtg_pkg::CORD_W-1:0]  ys;
  logic signed [gtg_pkg::CORD_W-1:0]  x_ext;
  logic signed [gtg_pkg::CORD_W-1:0]  y_ext;
  logic signed [gtg_pkg::ANG_W-1:0]   step;
  logic                               zero_vec;

  assign x_ext    = gtg_pkg::CORD_W'(x_i);
  assign y_ext    = gtg_pkg::CORD_W'(y_i);
  assign zero_vec = (x_i == '0) && (y_i == '0);
  assign xs       = x_q >>> iter_q;
  assign ys       = y_q >>> iter_q;
  assign step     = $signed({{(gtg_pkg::ANG_W-30){1'b0}},
                             gtg_pkg::atan_q29(5'(iter_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= !zero_vec;
      iter_q <= '0;
    end else if (busy_q) begin
      if (iter_q == IW'(NITER - 1)) begin
        busy_q <= 1'b0;
      end else begin
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        x_q <= -x_ext;
        y_q <= -y_ext;
        z_q <= gtg_pkg::PI_Q29;
      end else begin
        x_q <= x_ext;
        y_q <= y_ext;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + step;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - step;
      end
    end
  end

  assign busy_o  = busy_q;
  assign angle_o = z_q;

endmodule

[design/go_to_goal_controller.sv]
// Top level of the proportional go-to-goal controller: sequencer, shared multiplier, registers.
//
//   port      role    beat
//   pose_i    sink    pos_x, pos_y (Q16.16), heading (Q3.13)
//   cmd_o     source  linear_speed (Q15.16), angular_speed (Q16.16), arrived
//   cfg_*_i   write   register index and data, one write per enabled cycle
//
// Each pose runs through the 32-step square root while the CORDIC runs alongside it;
// the heading error is then wrapped into range before the angular product.
// An arriving pose ends at the distance check; once arrived, a pose goes from accept straight to the output.
// Reset clears the arrived latch and loads the register defaults.
// pose_i is ready only between poses; a waiting result is held in the output register.
module go_to_goal_controller #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtg_pose_if.sink    pose_i,
  gtg_cmd_if.source   cmd_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SQ_A, ST_SQ_B, ST_SUM, ST_ROOT, ST_CHECK,
    ST_LIN, ST_WAIT_Z, ST_WRAP, ST_ANG, ST_DONE
  } state_e;

  localparam int unsigned MA_W = 34;
  localparam int unsigned MB_W = 32;
  localparam int unsigned MP_W = MA_W + MB_W;

  state_e state_q;
  logic   arrived_q;
  logic   out_valid_q;
  gtg_pkg::cmd_t out_q;
  gtg_pkg::cmd_t res_q;

  logic [31:0] goal_x_q;
  logic [31:0] goal_y_q;
  logic [15:0] lin_gain_q;
  logic [15:0] ang_gain_q;
  logic [31:0] stop_dist_q;

  logic signed [15:0]                  heading_q;
  logic signed [gtg_pkg::DIFF_W-1:0]   dx_q;
  logic signed [gtg_pkg::DIFF_W-1:0]   dy_q;
  logic [30:0]                         a_q;
  logic [30:0]                         b_q;
  logic                                half_q;
  logic [61:0]                         sq_a_q;
  logic [gtg_pkg::DIFF_W-1:0]          dist_q;
  logic signed [gtg_pkg::ANG_W-1:0]    err_q;
  logic signed [MP_W-1:0]              mul_q;

  logic signed [MA_W-1:0]              mul_a;
  logic signed [MB_W-1:0]              mul_b;
  logic signed [gtg_pkg::DIFF_W-1:0]   dx_new;
  logic signed [gtg_pkg::DIFF_W-1:0]   dy_new;
  logic [gtg_pkg::DIFF_W-1:0]          abs_x;
  logic [gtg_pkg::DIFF_W-1:0]          abs_y;
  logic                                pose_acc;
  logic                                out_free;
  logic                                root_start;
  logic                                cord_start;
  logic                                root_busy;
  logic                                cord_busy;
  logic [gtg_pkg::RAD_W-1:0]           radicand;
  logic [gtg_pkg::ROOT_W-1:0]          root;
  logic signed [gtg_pkg::ANG_W-1:0]    bearing;
  logic signed [gtg_pkg::ANG_W-1:0]    head_q29;

  assign pose_i.ready = (state_q == ST_IDLE);
  assign pose_acc     = pose_i.valid && pose_i.ready;
  assign out_free     = !out_valid_q || cmd_o.ready;
  assign cmd_o.valid   = out_valid_q;
  assign cmd_o.payload = out_q;

  assign dx_new = $signed({goal_x_q[31], goal_x_q}) - $signed({pose_i.payload.pos_x[31],
                                                               pose_i.payload.pos_x});
  assign dy_new = $signed({goal_y_q[31], goal_y_q}) - $signed({pose_i.payload.pos_y[31],
                                                               pose_i.payload.pos_y});
  assign abs_x  = dx_q[gtg_pkg::DIFF_W-1] ? -dx_q : dx_q;
  assign abs_y  = dy_q[gtg_pkg::DIFF_W-1] ? -dy_q : dy_q;

  assign root_start = (state_q == ST_SUM);
  assign cord_start = (state_q == ST_PREP);
  assign radicand   = gtg_pkg::RAD_W'(sq_a_q) + gtg_pkg::RAD_W'(mul_q[61:0]);
  assign head_q29   = gtg_pkg::ANG_W'(heading_q) <<< 16;

  gtg_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (radicand),
    .busy_o     (root_busy),
    .root_o     (root)
  );

  gtg_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (dx_q),
    .y_i     (dy_q),
    .busy_o  (cord_busy),
    .angle_o (bearing)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ_A: begin
        mul_a = $signed(MA_W'(a_q));
        mul_b = $signed(MB_W'(a_q));
      end
      ST_SQ_B: begin
        mul_a = $signed(MA_W'(b_q));
        mul_b = $signed(MB_W'(b_q));
      end
      ST_CHECK: begin
        mul_a = $signed(MA_W'(dist_q));
        mul_b = $signed(MB_W'(lin_gain_q));
      end
      ST_WRAP: begin
        mul_a = err_q;
        mul_b = $signed(MB_W'(ang_gain_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q    <= gtg_pkg::GOAL_X_RST;
      goal_y_q    <= gtg_pkg::GOAL_Y_RST;
      lin_gain_q  <= gtg_pkg::LINEAR_GAIN_RST;
      ang_gain_q  <= gtg_pkg::ANGULAR_GAIN_RST;
      stop_dist_q <= gtg_pkg::STOP_DIST_RST;
    end else if (cfg_we_i) begin
      case (gtg_pkg::cfg_idx_e'(cfg_idx_i))
        gtg_pkg::CFG_GOAL_X:       goal_x_q    <= cfg_wdata_i;
        gtg_pkg::CFG_GOAL_Y:       goal_y_q    <= cfg_wdata_i;
        gtg_pkg::CFG_LINEAR_GAIN:  lin_gain_q  <= cfg_wdata_i[15:0];
        gtg_pkg::CFG_ANGULAR_GAIN: ang_gain_q  <= cfg_wdata_i[15:0];
        gtg_pkg::CFG_STOP_DIST:    stop_dist_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      arrived_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_q       <= '0;
    end else begin
      if (cmd_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pose_acc) begin
            if (arrived_q) begin
              res_q   <= '{linear_speed: '0, angular_speed: '0, arrived: 1'b1};
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP:  state_q <= ST_SQ_A;
        ST_SQ_A:  state_q <= ST_SQ_B;
        ST_SQ_B:  state_q <= ST_SUM;
        ST_SUM:   state_q <= ST_ROOT;
        ST_ROOT: begin
          if (!root_busy) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (dist_q < {1'b0, stop_dist_q}) begin
            arrived_q <= 1'b1;
            res_q     <= '{linear_speed: '0, angular_speed: '0, arrived: 1'b1};
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_LIN;
          end
        end
        ST_LIN: begin
          res_q.linear_speed <= (|mul_q[MP_W-1:39]) ? '1 : mul_q[38:8];
          res_q.arrived      <= 1'b0;
          state_q            <= ST_WAIT_Z;
        end
        ST_WAIT_Z: begin
          if (!cord_busy) begin
            state_q <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (err_q >= -gtg_pkg::PI_Q29 && err_q < gtg_pkg::PI_Q29) begin
            state_q <= ST_ANG;
          end
        end
        ST_ANG: begin
          res_q.angular_speed <= mul_q[52:21];
          state_q             <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (pose_acc) begin
          dx_q      <= dx_new;
          dy_q      <= dy_new;
          heading_q <= pose_i.payload.heading;
        end
      end
      ST_PREP: begin
        half_q <= abs_x[31] || abs_y[31];
        a_q    <= (abs_x[31] || abs_y[31]) ? abs_x[31:1] : abs_x[30:0];
        b_q    <= (abs_x[31] || abs_y[31]) ? abs_y[31:1] : abs_y[30:0];
      end
      ST_SQ_B: begin
        sq_a_q <= mul_q[61:0];
      end
      ST_ROOT: begin
        dist_q <= half_q ? {root, 1'b0} : {1'b0, root};
      end
      ST_WAIT_Z: begin
        err_q <= bearing - head_q29;
      end
      ST_WRAP: begin
        if (err_q >= gtg_pkg::PI_Q29) begin
          err_q <= err_q - gtg_pkg::TWO_PI_Q29;
        end else if (err_q < -gtg_pkg::PI_Q29) begin
          err_q <= err_q + gtg_pkg::TWO_PI_Q29;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrived_q |=> arrived_q)
    else $error("arrived latch cleared without reset");

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && cmd_o.payload.arrived) |->
      (cmd_o.payload.linear_speed == '0 && cmd_o.payload.angular_speed == '0))
    else $error("arrived beat carries non-zero speed");

  a_err_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ANG) |-> (err_q >= -gtg_pkg::PI_Q29 && err_q < gtg_pkg::PI_Q29))
    else $error("heading error outside wrap range");
`endif

endmodule

[sim/go_to_goal_controller_tb.sv]
// Self-checking testbench of the go-to-goal controller: directed table, random poses, predictor.
module go_to_goal_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CORDIC_N        = 16;
  localparam int     CFG_SPARE_FIRST = int'(gtg_pkg::CFG_STOP_DIST) + 1;
  localparam int     CFG_SPARE_LAST  = 7;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     DRAIN_CYCLES    = 60;
  localparam int     CYCLE_LIMIT     = 300000;
  localparam int     PHASE_ITEMS     = 95;
  localparam int     TAIL_ITEMS      = 30;
  localparam longint HALF_TURN       = gtg_pkg::PI_Q29;
  localparam longint FULL_TURN       = gtg_pkg::TWO_PI_Q29;

  typedef struct packed {
    logic [31:0] goal_x;
    logic [31:0] goal_y;
    logic [31:0] lin_gain;
    logic [31:0] ang_gain;
    logic [31:0] stop;
  } steer_cfg_t;

  typedef struct {
    int             cfg_no;
    gtg_pkg::pose_t pose;
    bit             typed;
    gtg_pkg::cmd_t  want;
  } steer_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  gtg_pose_if pose_if ();
  gtg_cmd_if  cmd_if ();

  go_to_goal_controller #(
    .CORDIC_ITERATIONS(CORDIC_N)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pose_i     (pose_if),
    .cmd_o      (cmd_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  logic signed [31:0] goal_x_r;
  logic signed [31:0] goal_y_r;
  logic [15:0]        lin_gain_r;
  logic [15:0]        ang_gain_r;
  logic [31:0]        stop_r;
  bit                 arrived_seen;

  longint bearing_step [0:9] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                                 16771758, 8387925, 4194219, 2097141, 1048575};

  gtg_pkg::cmd_t cmd_due [$];
  steer_row_t    steer_rows [$];
  steer_cfg_t    dir_cfg [0:4];
  int            cur_cfg;
  int            n_opening;
  int            mismatch_cnt = 0;
  int            cycle_cnt = 0;
  int            snd_idle_pct = 0;
  int            rcv_idle_pct = 0;
  logic          hold_kick = 1'b0;
  logic          hold_seen = 1'b0;
  int            hold_left = 0;
  gtg_pkg::cmd_t got_cmd;
  gtg_pkg::cmd_t want_cmd;

  function automatic longint unsigned goal_range(input gtg_pkg::pose_t p);
    longint          dx, dy;
    longint unsigned a, b, sq, r, t;
    int              sh, k;
    dx = longint'(goal_x_r) - longint'(p.pos_x);
    dy = longint'(goal_y_r) - longint'(p.pos_y);
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    sh = 0;
    if (a >= (64'd1 << 31) || b >= (64'd1 << 31)) begin
      a = a >> 1;
      b = b >> 1;
      sh = 1;
    end
    sq = a * a + b * b;
    r = 0;
    for (k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= sq) r = t;
    end
    return r << sh;
  endfunction

  function automatic longint goal_bearing(input longint x, input longint y);
    longint z, xs, ys, step;
    int     k;
    if (x == 0 && y == 0) return 0;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (k = 0; k < ((CORDIC_N > 32) ? 32 : CORDIC_N); k++) begin
      xs = x >>> k;
      ys = y >>> k;
      step = (k < 10) ? bearing_step[k] : ((64'sd1 << 29) >>> k);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    return z;
  endfunction

  function automatic gtg_pkg::cmd_t cmd_for_pose(input gtg_pkg::pose_t p);
    gtg_pkg::cmd_t   c;
    longint unsigned d, lin;
    longint          err, ang;
    c = '0;
    c.arrived = 1'b1;
    if (arrived_seen) return c;
    d = goal_range(p);
    if (d < stop_r) begin
      arrived_seen = 1'b1;
      return c;
    end
    lin = (64'(lin_gain_r) * d) >> 8;
    if (lin > 64'h7FFF_FFFF) lin = 64'h7FFF_FFFF;
    err = goal_bearing(longint'(goal_x_r) - longint'(p.pos_x),
                       longint'(goal_y_r) - longint'(p.pos_y))
          - longint'(p.heading) * 65536;
    err = (err + HALF_TURN) % FULL_TURN;
    if (err < 0) err = err + FULL_TURN;
    err = err - HALF_TURN;
    ang = (longint'({48'd0, ang_gain_r}) * err) >>> 21;
    c.linear_speed  = lin[30:0];
    c.angular_speed = ang[31:0];
    c.arrived       = 1'b0;
    return c;
  endfunction

  function automatic steer_cfg_t rand_cfg();
    steer_cfg_t c;
    c.goal_x = $urandom;
    c.goal_y = $urandom;
    if ($urandom_range(1) != 0) c.goal_x = {{12{c.goal_x[31]}}, c.goal_x[31:12]};
    if ($urandom_range(1) != 0) c.goal_y = {{12{c.goal_y[31]}}, c.goal_y[31:12]};
    case ($urandom_range(3))
      0:       c.lin_gain = {16'($urandom), 16'h0000};
      1:       c.lin_gain = {16'($urandom), 16'hFFFF};
      default: c.lin_gain = $urandom;
    endcase
    case ($urandom_range(3))
      0:       c.ang_gain = {16'($urandom), 16'h0000};
      1:       c.ang_gain = {16'($urandom), 16'hFFFF};
      default: c.ang_gain = $urandom;
    endcase
    case ($urandom_range(2))
      0:       c.stop = 32'd0;
      1:       c.stop = $urandom_range(0, 65536);
      default: c.stop = $urandom_range(0, 1 << 20);
    endcase
    return c;
  endfunction

  function automatic gtg_pkg::pose_t rand_pose(input bit allow_arrival);
    gtg_pkg::pose_t     p;
    logic signed [31:0] off;
    do begin
      off = $urandom;
      off = off >>> $urandom_range(0, 31);
      p.pos_x = goal_x_r - off;
      off = $urandom;
      off = off >>> $urandom_range(0, 31);
      p.pos_y = goal_y_r - off;
      if ($urandom_range(19) == 0) begin
        p.pos_x = goal_x_r;
        p.pos_y = goal_y_r;
      end
      p.heading = 16'(int'($urandom_range(0, 51472)) - 25736);
    end while (!allow_arrival && goal_range(p) < stop_r);
    return p;
  endfunction

  task automatic cfg_beat(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_cfg(input steer_cfg_t c);
    int k;
    cfg_beat(gtg_pkg::CFG_GOAL_X, c.goal_x);
    cfg_beat(gtg_pkg::CFG_GOAL_Y, c.goal_y);
    cfg_beat(gtg_pkg::CFG_LINEAR_GAIN, c.lin_gain);
    cfg_beat(gtg_pkg::CFG_ANGULAR_GAIN, c.ang_gain);
    cfg_beat(gtg_pkg::CFG_STOP_DIST, c.stop);
    for (k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) cfg_beat(3'(k), $urandom);
    cfg_we_i   <= 1'b0;
    goal_x_r   = c.goal_x;
    goal_y_r   = c.goal_y;
    lin_gain_r = c.lin_gain[15:0];
    ang_gain_r = c.ang_gain[15:0];
    stop_r     = c.stop;
  endtask

  // drop valid and wait until every expected beat is back
  task automatic settle();
    pose_if.valid <= 1'b0;
    while (cmd_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic offer_pose(input gtg_pkg::pose_t p, input bit typed,
                            input gtg_pkg::cmd_t typed_want);
    int            gap;
    gtg_pkg::cmd_t due;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      pose_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pose_if.valid   <= 1'b1;
    pose_if.payload <= p;
    do @(posedge clk_i); while (!pose_if.ready);
    due = cmd_for_pose(p);
    cmd_due.push_back(typed ? typed_want : due);
  endtask

  task automatic add_row(input int cfg_no, input logic [31:0] x, input logic [31:0] y,
                         input logic [15:0] h, input bit typed, input logic [30:0] lin,
                         input logic [31:0] ang, input logic arr);
    steer_row_t r;
    r.cfg_no               = cfg_no;
    r.pose.pos_x           = x;
    r.pose.pos_y           = y;
    r.pose.heading         = h;
    r.typed                = typed;
    r.want.linear_speed    = lin;
    r.want.angular_speed   = ang;
    r.want.arrived         = arr;
    steer_rows.push_back(r);
  endtask

  task automatic run_rows(input int first, input int last);
    int i;
    for (i = first; i <= last; i++) begin
      if (steer_rows[i].cfg_no != cur_cfg) begin
        settle();
        load_cfg(dir_cfg[steer_rows[i].cfg_no]);
        cur_cfg = steer_rows[i].cfg_no;
      end
      offer_pose(steer_rows[i].pose, steer_rows[i].typed, steer_rows[i].want);
    end
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct <= rcv;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("go_to_goal_controller_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      got_cmd = cmd_if.payload;
      if (cmd_due.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat: expected none, got %0d %0d %0b", $time,
                 got_cmd.linear_speed, got_cmd.angular_speed, got_cmd.arrived);
      end else begin
        want_cmd = cmd_due.pop_front();
        if (got_cmd.linear_speed !== want_cmd.linear_speed) begin
          mismatch_cnt++;
          $display("%0t: linear_speed expected %0d, got %0d", $time,
                   want_cmd.linear_speed, got_cmd.linear_speed);
        end
        if (got_cmd.angular_speed !== want_cmd.angular_speed) begin
          mismatch_cnt++;
          $display("%0t: angular_speed expected %0d, got %0d", $time,
                   want_cmd.angular_speed, got_cmd.angular_speed);
        end
        if (got_cmd.arrived !== want_cmd.arrived) begin
          mismatch_cnt++;
          $display("%0t: arrived expected %0b, got %0b", $time,
                   want_cmd.arrived, got_cmd.arrived);
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      cmd_if.ready <= 1'b0;
    end else if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    int ph;
    int n;
    pose_if.valid   <= 1'b0;
    pose_if.payload <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= gtg_pkg::CFG_GOAL_X;
    cfg_wdata_i     <= '0;
    goal_x_r        = gtg_pkg::GOAL_X_RST;
    goal_y_r        = gtg_pkg::GOAL_Y_RST;
    lin_gain_r      = gtg_pkg::LINEAR_GAIN_RST;
    ang_gain_r      = gtg_pkg::ANGULAR_GAIN_RST;
    stop_r          = gtg_pkg::STOP_DIST_RST;
    arrived_seen    = 1'b0;

    dir_cfg[0] = '{gtg_pkg::GOAL_X_RST, gtg_pkg::GOAL_Y_RST,
                   32'(gtg_pkg::LINEAR_GAIN_RST), 32'(gtg_pkg::ANGULAR_GAIN_RST),
                   gtg_pkg::STOP_DIST_RST};
    dir_cfg[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5A5A_FFFF, 32'hC3C3_FFFF, 32'd0};
    dir_cfg[2] = '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 32'h1234_0000, 32'd0};
    dir_cfg[3] = '{-32'sd196608, 32'd327680, 32'd256, 32'd256, 32'd65536};
    dir_cfg[4] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd128, 32'd768, 32'hFFFF_FFFF};

    add_row(0, 32'd65536, 32'd0, 16'd0, 0, '0, '0, 1'b0);
    add_row(0, 32'd0, 32'd65536, 16'd25736, 0, '0, '0, 1'b0);
    add_row(0, 32'd0, -32'sd65536, -16'sd25736, 0, '0, '0, 1'b0);
    add_row(0, 32'h8000_0000, 32'h8000_0000, 16'd0, 0, '0, '0, 1'b0);
    add_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd12868, 0, '0, '0, 1'b0);
    add_row(0, -32'sd65536, -32'sd65536, -16'sd8192, 0, '0, '0, 1'b0);
    add_row(0, 32'd3277, 32'd0, 16'd0, 0, '0, '0, 1'b0);
    add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 1, '0, '0, 1'b0);
    add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8192, 0, '0, '0, 1'b0);
    add_row(1, 32'h8000_0000, 32'h8000_0000, -16'sd25736, 0, '0, '0, 1'b0);
    add_row(1, 32'h8000_0000, 32'h7FFF_FFFF, 16'd25736, 0, '0, '0, 1'b0);
    add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 0, '0, '0, 1'b0);
    add_row(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd25736, 1, '0, '0, 1'b0);
    add_row(2, 32'd0, 32'd0, -16'sd25736, 1, '0, '0, 1'b0);
    add_row(2, 32'h8000_0000, 32'h8000_0000, 16'd0, 1, '0, '0, 1'b0);
    add_row(3, -32'sd131072, 32'd327680, 16'd0, 0, '0, '0, 1'b0);
    add_row(3, -32'sd196608, 32'd589824, 16'd4096, 0, '0, '0, 1'b0);
    n_opening = steer_rows.size();
    add_row(4, 32'h8000_0000, 32'h8000_0000, 16'd0, 0, '0, '0, 1'b0);
    add_row(4, 32'd0, 32'd0, 16'd0, 1, '0, '0, 1'b1);
    add_row(4, 32'h8000_0000, 32'h8000_0000, 16'd25736, 1, '0, '0, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(28, 77);
    cur_cfg = 0;
    run_rows(0, n_opening - 1);

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 2) set_idling(77, 28);
      if (ph == 4) set_idling(0, 0);
      settle();
      load_cfg(rand_cfg());
      cur_cfg = -1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 50 && ph % 2 == 1) settle();
        if (n == 10 && ph == 4) hold_kick <= ~hold_kick;
        offer_pose(rand_pose(1'b0), 1'b0, '0);
      end
    end

    // arrival latches for good, so the arriving poses come last
    set_idling(28, 77);
    run_rows(n_opening, steer_rows.size() - 1);
    for (n = 0; n < TAIL_ITEMS; n++) offer_pose(rand_pose(1'b1), 1'b0, '0);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("go_to_goal_controller_tb OK");
    end else begin
      $display("go_to_goal_controller_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
design/gtg_pkg.sv
design/gtg_if.sv
design/gtg_isqrt.sv
design/gtg_cordic.sv
design/go_to_goal_controller.sv
sim/go_to_goal_controller_tb.sv
